// ===== rtl/complex_arithmetic_unit_top_defines.svh =====
// Assertion macros shared by the complex arithmetic unit modules.
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`ifndef SYNTH
`define CAU_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CAU_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CAU_ASSERT(label, clk, rst, prop, msg)
`define CAU_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/cau_pkg.sv =====
// Package with request and result types and operation codes for the complex unit.
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;
  localparam int unsigned KindWidth = 3;
  localparam int unsigned WordWidth = 32;
  localparam int unsigned FractionBits = 16;
  localparam int unsigned FieldWidth = WordWidth;

  typedef enum logic [KindWidth-1:0] {
    KIND_ADD  = 3'd0,
    KIND_SUB  = 3'd1,
    KIND_MUL  = 3'd2,
    KIND_DIV  = 3'd3,
    KIND_CONJ = 3'd4
  } kind_t;

  typedef struct packed {
    logic [KindWidth-1:0]         kind;
    logic signed [FieldWidth-1:0] a_re;
    logic signed [FieldWidth-1:0] a_im;
    logic signed [FieldWidth-1:0] b_re;
    logic signed [FieldWidth-1:0] b_im;
  } req_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] res_re;
    logic signed [FieldWidth-1:0] res_im;
    logic                         overflow;
    logic                         divide_by_zero;
    logic                         operands_equal;
  } res_t;
endpackage
`default_nettype wire

// ===== rtl/cau_front.sv =====
// Front end: accepts requests, checks operand equality and the zero divisor.
`timescale 1ns / 1ps
`default_nettype none
module cau_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire cau_pkg::req_t req,
  output logic               fq_valid,
  input  wire logic          fq_ready,
  output cau_pkg::req_t      fq_req,
  output logic               fq_eq,
  output logic               fq_dz
);
  import cau_pkg::*;

  localparam int unsigned Depth = 2;

  req_t        mem_req [Depth];
  logic        mem_eq  [Depth];
  logic        mem_dz  [Depth];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign full     = (count == 2'(Depth));
  assign do_push  = push && !full;
  assign fq_valid = (count != 2'd0);
  assign do_pop   = fq_valid && fq_ready;
  assign fq_req   = mem_req[rd_ptr];
  assign fq_eq    = mem_eq[rd_ptr];
  assign fq_dz    = mem_dz[rd_ptr];

  // Classify on entry: equality for every kind, zero divisor for divide only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_req[wr_ptr] <= req;
      mem_eq[wr_ptr]  <= (req.a_re == req.b_re) && (req.a_im == req.b_im);
      mem_dz[wr_ptr]  <= (req.kind == KIND_DIV) && (req.b_re == '0) && (req.b_im == '0);
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  `include "complex_arithmetic_unit_top_defines.svh"
  `CAU_ASSERT(a_no_over, clk, rst, full |-> !do_push, "front queue overfilled")
  `CAU_ASSERT(a_cnt_max, clk, rst, count <= 2'(Depth), "front count out of range")
  `CAU_ASSERT(a_cnt_step, clk, rst, (do_push && !do_pop) |=> count == $past(count) + 2'd1, "front count step")
endmodule
`default_nettype wire

// ===== rtl/cau_back.sv =====
// Back end: pipelined complex add, subtract, multiply, conjugate and divide.
`timescale 1ns / 1ps
`default_nettype none
module cau_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cau_pkg::req_t in_req,
  input  wire logic          in_eq,
  input  wire logic          in_dz,
  output logic               out_valid,
  input  wire logic          out_ready,
  output cau_pkg::res_t      out_res
);
  import cau_pkg::*;

  localparam int unsigned W   = WordWidth;
  localparam int unsigned F   = FractionBits;
  localparam int unsigned PW  = 2 * W + 1;       // sum of two products, signed
  localparam int unsigned NW  = PW + F + 1;      // scaled numerator
  localparam int unsigned DS  = NW;              // divider steps, one bit each
  localparam int unsigned LAT = DS + 4;          // total pipeline depth
  localparam int unsigned CW  = $clog2(LAT + 4);

  typedef struct packed {
    logic [KindWidth-1:0] kind;
    logic                 eq;
    logic                 dz;
  } tag_t;

  // Stage 1: operand capture at word width.
  logic              v1;
  tag_t              t1;
  logic signed [W-1:0] ar1, ai1, br1, bi1;
  // Stage 2: six products and the add or subtract sums.
  logic              v2;
  tag_t              t2;
  logic signed [W-1:0] ar2, ai2;
  logic signed [W:0]   s_re2, s_im2;
  logic signed [2*W-1:0] p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;
  // Stage 3: product sums.
  logic              v3;
  tag_t              t3;
  logic signed [W:0]   s_re3, s_im3;
  logic signed [W-1:0] ar3, ai3;
  logic signed [PW-1:0] m_re3, m_im3, n_re3, n_im3;
  logic [PW-1:0]        den3;
  // Divider pipeline.
  logic              dv   [DS+1];
  tag_t              dt   [DS+1];
  logic [NW-1:0]     dnr  [DS+1];
  logic [NW-1:0]     dni  [DS+1];
  logic [NW:0]       drr  [DS+1];
  logic [NW:0]       dri  [DS+1];
  logic [PW:0]       dd   [DS+1];
  logic              dngr [DS+1];
  logic              dngi [DS+1];
  // Output stage.
  logic              v4;
  res_t              r4;

  logic advance;
  logic [CW-1:0] credit;

  // The whole pipeline moves together; the result queue grants space ahead.
  assign advance  = 1'b1;
  assign in_ready = (credit != '0);

  function automatic logic signed [W-1:0] sat_w(input logic signed [NW:0] x,
                                                output logic o);
    logic signed [NW:0] hi;
    logic signed [NW:0] lo;
    hi = (NW+1)'(signed'({1'b0, {(W-1){1'b1}}}));
    lo = -hi - (NW+1)'(1);
    o = 1'b0;
    if (x > hi) begin
      o = 1'b1;
      sat_w = {1'b0, {(W-1){1'b1}}};
    end else if (x < lo) begin
      o = 1'b1;
      sat_w = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat_w = x[W-1:0];
    end
  endfunction

  // Round to nearest, ties away from zero, dropping F fraction bits.
  function automatic logic signed [NW:0] rnd_shr(input logic signed [PW-1:0] x);
    logic        ng;
    logic [PW:0] mag;
    ng  = x[PW-1];
    mag = ng ? (PW+1)'(-x) : (PW+1)'(x);
    if (F > 0) mag = (mag + ((PW+1)'(1) << (F - 1))) >> F;
    rnd_shr = ng ? -(NW+1)'(mag) : (NW+1)'(mag);
  endfunction

  // Stage 1 and 2: capture, add or subtract, and multiply.
  always_ff @(posedge clk) begin
    ar1 <= in_req.a_re[W-1:0];
    ai1 <= in_req.a_im[W-1:0];
    br1 <= in_req.b_re[W-1:0];
    bi1 <= in_req.b_im[W-1:0];
    t1  <= '{kind: in_req.kind, eq: in_eq, dz: in_dz};
    t2    <= t1;
    ar2   <= ar1;
    ai2   <= ai1;
    s_re2 <= (t1.kind == KIND_SUB) ? (W+1)'(ar1) - (W+1)'(br1) : (W+1)'(ar1) + (W+1)'(br1);
    s_im2 <= (t1.kind == KIND_SUB) ? (W+1)'(ai1) - (W+1)'(bi1) : (W+1)'(ai1) + (W+1)'(bi1);
    p_rr  <= ar1 * br1;
    p_ii  <= ai1 * bi1;
    p_ri  <= ar1 * bi1;
    p_ir  <= ai1 * br1;
    p_bb  <= br1 * br1;
    p_cc  <= bi1 * bi1;
  end

  // Stage 3: product sums for multiply and for the divide numerators and denominator.
  always_ff @(posedge clk) begin
    t3    <= t2;
    s_re3 <= s_re2;
    s_im3 <= s_im2;
    ar3   <= ar2;
    ai3   <= ai2;
    m_re3 <= PW'(p_rr) - PW'(p_ii);
    m_im3 <= PW'(p_ri) + PW'(p_ir);
    n_re3 <= PW'(p_rr) + PW'(p_ii);
    n_im3 <= PW'(p_ir) - PW'(p_ri);
    den3  <= PW'(p_bb) + PW'(p_cc);
  end

  // Divider entry: magnitudes, scaled by 2^(F+1), plus d for rounding.
  always_comb begin
    logic [PW-1:0] mr;
    logic [PW-1:0] mi;
    mr = n_re3[PW-1] ? PW'(-n_re3) : PW'(n_re3);
    mi = n_im3[PW-1] ? PW'(-n_im3) : PW'(n_im3);
    dv[0]   = v3;
    dt[0]   = t3;
    dnr[0]  = (NW'(mr) << (F + 1)) + NW'(den3);
    dni[0]  = (NW'(mi) << (F + 1)) + NW'(den3);
    drr[0]  = '0;
    dri[0]  = '0;
    dd[0]   = {den3, 1'b0};
    dngr[0] = n_re3[PW-1];
    dngi[0] = n_im3[PW-1];
  end

  // Mul, conj and add/sub results ride through the divider stages in the mres slots.
  logic signed [NW:0] mres_re [DS+1];
  logic signed [NW:0] mres_im [DS+1];
  assign mres_re[0] = (t3.kind == KIND_CONJ) ? (NW+1)'(ar3) :
                      (t3.kind == KIND_MUL) ? rnd_shr(m_re3) : (NW+1)'(s_re3);
  assign mres_im[0] = (t3.kind == KIND_CONJ) ? -(NW+1)'(ai3) :
                      (t3.kind == KIND_MUL) ? rnd_shr(m_im3) : (NW+1)'(s_im3);

  // Restoring divider, one quotient bit per stage for both parts.
  for (genvar g = 0; g < DS; g++) begin : g_div
    always_ff @(posedge clk) begin
      logic [NW:0] rr;
      logic [NW:0] ri;
      rr = {drr[g][NW-1:0], dnr[g][NW-1]};
      ri = {dri[g][NW-1:0], dni[g][NW-1]};
      if (rst) begin
        dv[g+1] <= 1'b0;
      end else begin
        dv[g+1] <= dv[g];
      end
      dt[g+1]      <= dt[g];
      dd[g+1]      <= dd[g];
      dngr[g+1]    <= dngr[g];
      dngi[g+1]    <= dngi[g];
      mres_re[g+1] <= mres_re[g];
      mres_im[g+1] <= mres_im[g];
      if (rr >= (NW+1)'(dd[g])) begin
        drr[g+1] <= rr - (NW+1)'(dd[g]);
        dnr[g+1] <= {dnr[g][NW-2:0], 1'b1};
      end else begin
        drr[g+1] <= rr;
        dnr[g+1] <= {dnr[g][NW-2:0], 1'b0};
      end
      if (ri >= (NW+1)'(dd[g])) begin
        dri[g+1] <= ri - (NW+1)'(dd[g]);
        dni[g+1] <= {dni[g][NW-2:0], 1'b1};
      end else begin
        dri[g+1] <= ri;
        dni[g+1] <= {dni[g][NW-2:0], 1'b0};
      end
    end
  end

  // Valid bits of the pipeline outside the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid && in_ready;
      v2 <= v1;
      v3 <= v2;
      v4 <= dv[DS];
    end
  end

  // Final selection, saturation and flags.
  always_ff @(posedge clk) begin
    logic               o1;
    logic               o2;
    logic signed [NW:0] xr;
    logic signed [NW:0] xi;
    case (dt[DS].kind) inside
      KIND_DIV: begin
        xr = dngr[DS] ? -(NW+1)'(dnr[DS]) : (NW+1)'(dnr[DS]);
        xi = dngi[DS] ? -(NW+1)'(dni[DS]) : (NW+1)'(dni[DS]);
        if (dt[DS].dz) begin
          xr = '0;
          xi = '0;
        end
      end
      KIND_ADD, KIND_SUB, KIND_MUL, KIND_CONJ: begin
        xr = mres_re[DS];
        xi = mres_im[DS];
      end
      default: begin
        xr = '0;
        xi = '0;
      end
    endcase
    r4.res_re         <= FieldWidth'(sat_w(xr, o1));
    r4.res_im         <= FieldWidth'(sat_w(xi, o2));
    r4.overflow       <= o1 | o2;
    r4.divide_by_zero <= dt[DS].dz;
    r4.operands_equal <= dt[DS].eq;
  end

  // Result queue sized to cover the pipeline; credit counts free slots.
  // The memory is read into the output register, which holds the oldest result.
  localparam int unsigned RQ = LAT + 3;
  localparam int unsigned RW = $clog2(RQ);
  res_t          rq [RQ];
  logic [RW-1:0] rq_wr;
  logic [RW-1:0] rq_rd;
  logic [CW-1:0] rq_cnt;
  logic          rq_rd_en;
  logic          rq_pop;
  logic          ov;
  res_t          ores;

  assign out_valid = ov;
  assign out_res   = ores;
  assign rq_pop    = ov && out_ready;
  assign rq_rd_en  = (rq_cnt != '0) && (!ov || out_ready);

  always_ff @(posedge clk) begin
    if (v4) rq[rq_wr] <= r4;
    if (rq_rd_en) ores <= rq[rq_rd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr  <= '0;
      rq_rd  <= '0;
      rq_cnt <= '0;
      ov     <= 1'b0;
      credit <= CW'(RQ);
    end else begin
      if (v4) rq_wr <= (rq_wr == RW'(RQ - 1)) ? '0 : rq_wr + RW'(1);
      if (rq_rd_en) rq_rd <= (rq_rd == RW'(RQ - 1)) ? '0 : rq_rd + RW'(1);
      rq_cnt <= rq_cnt + CW'(v4) - CW'(rq_rd_en);
      if (rq_rd_en) ov <= 1'b1;
      else if (rq_pop) ov <= 1'b0;
      credit <= credit - CW'(in_valid && in_ready) + CW'(rq_pop);
    end
  end

  `include "complex_arithmetic_unit_top_defines.svh"
  `CAU_ASSERT(a_rq_room, clk, rst, v4 |-> rq_cnt < CW'(RQ), "result queue overrun")
  `CAU_ASSERT(a_credit, clk, rst, credit <= CW'(RQ), "credit out of range")
  `CAU_ASSERT(a_dz_zero, clk, rst, (v4 && r4.divide_by_zero) |-> (r4.res_re == '0 && !r4.overflow), "divide by zero not cleared")
  `CAU_ASSERT_NR(a_adv, clk, advance, "pipeline stalled")
endmodule
`default_nettype wire

// ===== rtl/complex_arithmetic_unit_top.sv =====
// Top level of the complex arithmetic unit.
// Accepts one request per cycle (push while full is low) and returns one result per
// request in order. Every request passes through the capture, product and sum stages,
// the bit-serial pipelined divider, the output stage and the result queue; the front
// queue holds two requests and the result queue covers the whole pipeline, so
// throughput stays one request per cycle whenever pop keeps up. Division by zero
// gives zero with divide_by_zero set.
`timescale 1ns / 1ps
`default_nettype none
module complex_arithmetic_unit_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire cau_pkg::req_t req,
  output logic               empty,
  input  wire logic          pop,
  output cau_pkg::res_t      res
);
  import cau_pkg::*;

  logic fq_valid;
  logic fq_ready;
  req_t fq_req;
  logic fq_eq;
  logic fq_dz;
  logic out_valid;

  cau_front u_front (
    .clk, .rst, .push, .full, .req,
    .fq_valid, .fq_ready, .fq_req, .fq_eq, .fq_dz
  );

  cau_back u_back (
    .clk, .rst,
    .in_valid(fq_valid), .in_ready(fq_ready), .in_req(fq_req),
    .in_eq(fq_eq), .in_dz(fq_dz),
    .out_valid, .out_ready(pop), .out_res(res)
  );

  assign empty = !out_valid;
endmodule
`default_nettype wire

// ===== test/complex_arithmetic_unit_top_test.sv =====
// Self-checking testbench for the complex arithmetic unit top level.
`timescale 1ns / 1ps
`default_nettype none
module complex_arithmetic_unit_top_test;
  import cau_pkg::*;

  localparam int unsigned NumRandom = 2000;
  localparam int unsigned DrainCycles = 200;
  localparam logic signed [FieldWidth-1:0] MaxVal = 32'sh7fffffff;
  localparam logic signed [FieldWidth-1:0] MinVal = 32'sh80000000;
  localparam logic signed [FieldWidth-1:0] One = 32'sh00010000;
  localparam logic signed [FieldWidth-1:0] MinusOne = -32'sh00010000;

  // Tracks predicted results in request order and checks each returned result.
  class result_board;
    res_t pending[$];
    int   mismatches;

    static function logic signed [127:0] round_shr(logic signed [127:0] x);
      logic [127:0] mag;
      mag = x < 0 ? -x : x;
      mag = (mag + (128'd1 << (16 - 1))) >> 16;
      return x < 0 ? -$signed(mag) : $signed(mag);
    endfunction

    static function logic signed [127:0] div_round(logic signed [127:0] num,
                                                  logic signed [127:0] den);
      logic [127:0] mag;
      logic [127:0] q;
      mag = num < 0 ? -num : num;
      q = ((mag << 17) + den) / (den << 1);
      return num < 0 ? -$signed(q) : $signed(q);
    endfunction

    static function logic signed [FieldWidth-1:0] clamp(logic signed [127:0] x,
                                                       inout logic ovf);
      if (x > 128'sh7fffffff) begin
        ovf = 1'b1;
        return MaxVal;
      end
      if (x < -128'sh80000000) begin
        ovf = 1'b1;
        return MinVal;
      end
      return x[FieldWidth-1:0];
    endfunction

    // Computes the complex result, saturation and flags for one request.
    static function res_t compute(req_t r);
      logic signed [127:0] ar, ai, br, bi, re, im, den;
      logic ovf;
      res_t o;
      ar = r.a_re;
      ai = r.a_im;
      br = r.b_re;
      bi = r.b_im;
      re = 0;
      im = 0;
      ovf = 1'b0;
      o.divide_by_zero = 1'b0;
      case (kind_t'(r.kind))
        KIND_ADD: begin
          re = ar + br;
          im = ai + bi;
        end
        KIND_SUB: begin
          re = ar - br;
          im = ai - bi;
        end
        KIND_MUL: begin
          re = round_shr(ar * br - ai * bi);
          im = round_shr(ar * bi + ai * br);
        end
        KIND_DIV: begin
          den = br * br + bi * bi;
          if (den == 0) begin
            o.divide_by_zero = 1'b1;
          end else begin
            re = div_round(ar * br + ai * bi, den);
            im = div_round(ai * br - ar * bi, den);
          end
        end
        KIND_CONJ: begin
          re = ar;
          im = -ai;
        end
        default: begin
        end
      endcase
      o.res_re = clamp(re, ovf);
      o.res_im = clamp(im, ovf);
      o.overflow = ovf;
      o.operands_equal = (r.a_re == r.b_re) && (r.a_im == r.b_im);
      return o;
    endfunction

    function void note_request(req_t r);
      pending.push_back(compute(r));
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h", what, got, want);
      mismatches++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        report("unexpected result", got.res_re, 0);
        return;
      end
      want = pending.pop_front();
      if (got.res_re !== want.res_re) report("res_re", got.res_re, want.res_re);
      if (got.res_im !== want.res_im) report("res_im", got.res_im, want.res_im);
      if (got.overflow !== want.overflow) report("overflow", got.overflow, want.overflow);
      if (got.divide_by_zero !== want.divide_by_zero)
        report("divide_by_zero", got.divide_by_zero, want.divide_by_zero);
      if (got.operands_equal !== want.operands_equal)
        report("operands_equal", got.operands_equal, want.operands_equal);
    endtask
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  push = 1'b0;
  logic  pop = 1'b0;
  logic  no_gaps = 1'b0;
  req_t  req = '0;
  logic  full;
  logic  empty;
  res_t  res;
  result_board board = new();

  complex_arithmetic_unit_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .empty(empty), .pop(pop), .res(res)
  );

  always #10 clk = ~clk;

  // Result side: check accepted results, stall at random outside the gap-free stretch.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) board.check_result(res);
      if (no_gaps) pop <= 1'b1;
      else pop <= ($urandom_range(0, 99) >= 23);
    end
  end

  // Holds one request on the ports until it is accepted.
  task send(req_t r);
    push <= 1'b1;
    req <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_request(r);
  endtask

  task idle(int n);
    push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic signed [FieldWidth-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return MaxVal - $urandom_range(0, 2);
      1: return MinVal + $urandom_range(0, 2);
      2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t make(kind_t k, logic signed [FieldWidth-1:0] w, x, y, z);
    req_t r;
    r.kind = k;
    r.a_re = w;
    r.a_im = x;
    r.b_re = y;
    r.b_im = z;
    return r;
  endfunction

  initial begin
    req_t r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: extremes, every kind, unused kind codes, divide by zero, conjugate of min.
    send(make(KIND_ADD, MaxVal, MinVal, MaxVal, MinVal));
    send(make(KIND_ADD, One, MinusOne, One, One));
    send(make(KIND_SUB, MinVal, MaxVal, MaxVal, MinVal));
    send(make(KIND_SUB, One, One, One, One));
    send(make(KIND_MUL, MaxVal, MaxVal, MaxVal, MinVal));
    send(make(KIND_MUL, MinVal, MinVal, MinVal, MinVal));
    send(make(KIND_MUL, 32'sh00008000, 0, 1, 0));
    send(make(KIND_MUL, -32'sh00008000, 0, 1, 0));
    send(make(KIND_MUL, One, MinusOne, MinusOne, One));
    send(make(KIND_DIV, One, One, 0, 0));
    send(make(KIND_DIV, 0, 0, 0, 0));
    send(make(KIND_DIV, MaxVal, MinVal, 1, 0));
    send(make(KIND_DIV, One, 0, 3 * One, 0));
    send(make(KIND_DIV, MinVal, MinVal, MinVal, MinVal));
    send(make(KIND_DIV, 1, 0, MaxVal, MaxVal));
    send(make(KIND_CONJ, MinVal, MinVal, 0, 0));
    send(make(KIND_CONJ, MaxVal, MaxVal, 0, 0));
    send(make(KIND_CONJ, 0, 0, 0, 0));
    r = make(KIND_ADD, 5, 7, 5, 7);
    r.kind = 3'd5;
    send(r);
    r.kind = 3'd7;
    r.a_re = MaxVal;
    send(r);

    // Random requests with idle gaps, a gap-free stretch, and one full drain.
    for (int i = 0; i < NumRandom; i++) begin
      no_gaps <= (i >= 500 && i <= 900);
      if ((i < 500 || i > 900) && $urandom_range(0, 99) < 30)
        idle(1);
      if (i == 1000) begin
        push <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
      end
      r.kind = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
      r.a_re = rand_operand();
      r.a_im = rand_operand();
      r.b_re = rand_operand();
      r.b_im = rand_operand();
      if ($urandom_range(0, 9) == 0) begin
        r.b_re = r.a_re;
        r.b_im = r.a_im;
      end
      if (r.kind == KIND_DIV && $urandom_range(0, 9) == 0) begin
        r.b_re = 0;
        r.b_im = 0;
      end
      send(r);
    end
    push <= 1'b0;
    no_gaps <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire

// ===== complex_arithmetic_unit_top.f =====
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit_top.sv
test/complex_arithmetic_unit_top_test.sv
